// File: rtl/kpe_pkg.sv
// Shared types, event kind codes and the pin map of the keypad press event encoder.
// Has no dependencies; every other file in rtl/ imports it.
package kpe_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned NumPinsDflt = 16;
  localparam int unsigned KindWidth   = 3;
  localparam int unsigned CodeWidth   = 8;
  localparam int unsigned OutDataW    = 16;

  localparam logic [KindWidth-1:0] KIND_MATRIX = 3'd0;
  localparam logic [KindWidth-1:0] KIND_UP     = 3'd1;
  localparam logic [KindWidth-1:0] KIND_SELECT = 3'd2;
  localparam logic [KindWidth-1:0] KIND_DOWN   = 3'd3;
  localparam logic [KindWidth-1:0] KIND_RIGHT  = 3'd4;
  localparam logic [KindWidth-1:0] KIND_LEFT   = 3'd5;
  localparam logic [KindWidth-1:0] KIND_BACK   = 3'd6;
  localparam logic [KindWidth-1:0] KIND_ANY    = 3'd7;

  localparam logic [CodeWidth-1:0] SPACE_CODE  = 8'd32;

  // One event on its way from the scanner to the output register.
  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [CodeWidth-1:0] code;
    logic                 last;
  } kpe_event_t;

  // Event kind of each pin.
  function automatic logic [KindWidth-1:0] kpe_pin_kind(input logic [3:0] pin);
    logic [KindWidth-1:0] kind;
    unique case (pin)
      4'd0:    kind = KIND_UP;
      4'd1:    kind = KIND_SELECT;
      4'd2:    kind = KIND_DOWN;
      4'd8:    kind = KIND_RIGHT;
      4'd9:    kind = KIND_LEFT;
      4'd11:   kind = KIND_BACK;
      4'd14:   kind = KIND_ANY;
      default: kind = KIND_MATRIX;
    endcase
    return kind;
  endfunction

  // T9 table index for matrix pins, space for the any-key pin, zero otherwise.
  function automatic logic [CodeWidth-1:0] kpe_pin_code(input logic [3:0] pin);
    logic [CodeWidth-1:0] code;
    unique case (pin)
      4'd3:    code = 8'd8;
      4'd4:    code = 8'd4;
      4'd5:    code = 8'd1;
      4'd6:    code = 8'd3;
      4'd7:    code = 8'd7;
      4'd10:   code = 8'd6;
      4'd12:   code = 8'd0;
      4'd13:   code = 8'd2;
      4'd14:   code = SPACE_CODE;
      4'd15:   code = 8'd5;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/kpe_scan.sv
// Bit-serial press scanner: detects falling pin edges, shifts the press mask out
// one pin per cycle unless stalled and looks pressed pins up in kpe_pkg's pin map.
module kpe_scan #(
  parameter int unsigned NUM_PINS = kpe_pkg::NumPinsDflt
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            smp_valid_i,
  output logic                            smp_ready_o,
  input  logic [kpe_pkg::SampleWidth-1:0] smp_pins_i,
  output logic                            evt_valid_o,
  input  logic                            evt_ready_i,
  output kpe_pkg::kpe_event_t             evt_o
);
  import kpe_pkg::*;

  localparam int unsigned PinW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [SampleWidth-1:0] prev_q, prev_d;
  logic                   first_q, first_d;
  logic                   busy_q, busy_d;
  logic [NUM_PINS-1:0]    mask_q, mask_d;
  logic [PinW-1:0]        pin_q, pin_d;
  logic [SampleWidth-1:0] pressed;
  logic [NUM_PINS-1:0]    rest;
  logic                   accept;
  logic                   advance;

  assign smp_ready_o = !busy_q;
  assign accept      = smp_valid_i && !busy_q;
  assign pressed     = prev_q & ~smp_pins_i;
  assign rest        = mask_q >> 1;
  assign advance     = busy_q && (!mask_q[0] || evt_ready_i);

  assign evt_valid_o = busy_q && mask_q[0];
  assign evt_o.kind  = kpe_pin_kind(4'(pin_q));
  assign evt_o.code  = kpe_pin_code(4'(pin_q));
  assign evt_o.last  = (rest == '0);

  always_comb begin
    prev_d  = prev_q;
    first_d = first_q;
    busy_d  = busy_q;
    mask_d  = mask_q;
    pin_d   = pin_q;
    if (accept) begin
      prev_d  = smp_pins_i;
      first_d = 1'b0;
      mask_d  = pressed[NUM_PINS-1:0];
      pin_d   = '0;
      busy_d  = !first_q && (pressed[NUM_PINS-1:0] != '0);
    end else if (advance) begin
      mask_d = rest;
      pin_d  = pin_q + PinW'(1);
      busy_d = (rest != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '1;
      first_q <= 1'b1;
      busy_q  <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      first_q <= first_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    pin_q  <= pin_d;
  end

endmodule

// File: rtl/kpe_out.sv
// Output register of the encoder: holds one event until the sink takes it and
// packs it onto the stream bus. Uses kpe_pkg.
module kpe_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         evt_valid_i,
  output logic                         evt_ready_o,
  input  kpe_pkg::kpe_event_t          evt_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [kpe_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import kpe_pkg::*;

  logic       valid_q, valid_d;
  kpe_event_t evt_q, evt_d;

  assign evt_ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (evt_ready_o) begin
      valid_d = evt_valid_i;
      if (evt_valid_i) begin
        evt_d = evt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - KindWidth - CodeWidth){1'b0}}, evt_q.code, evt_q.kind};
  assign m_axis_tlast_o  = evt_q.last;

endmodule

// File: rtl/keypad_press_event_encoder.sv
// Top level of the keypad press event encoder: press scanner plus output register.
// Depends on kpe_pkg, kpe_scan and kpe_out.
//
// Usage: each item on the slave stream is one sample of sixteen active-low button
// pins. The first sample after reset is only stored and causes no events. For
// every later sample, each pin that went from high to low is a new press, and
// pins 0 to NUM_PINS-1 are scanned in ascending order, one pin per clock cycle.
// Every press leaves on the master stream as one item carrying the event kind and
// key code; tlast marks the final event caused by that sample.
// Timing: a sample that causes no events leaves the scanner idle. Otherwise the
// scanner is busy up to and including the highest pressed pin. A new sample is
// accepted in the cycle after the scanner has handed its last event to the
// output register, even while that event still waits there.
// Reset (rst_ni low, asynchronous) sets the stored previous sample to all ones,
// marks the next sample as the first one and empties the output register.
// If the receiver stalls, the output register holds its event, the scanner
// stops at the next pressed pin, and tready on the slave side stays low until
// the scan of the current sample is done.
module keypad_press_event_encoder #(
  parameter int unsigned NUM_PINS = kpe_pkg::NumPinsDflt
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] pin_sample
  input  logic [kpe_pkg::SampleWidth-1:0] s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [2:0] event_kind, [10:3] key_code, [15:11] zero
  output logic [kpe_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // last_event
  output logic                            m_axis_tlast_o
);
  import kpe_pkg::*;

  logic       evt_valid;
  logic       evt_ready;
  kpe_event_t evt;

  // Edge detection and the serial scan over the press mask.
  kpe_scan #(
    .NUM_PINS(NUM_PINS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (s_axis_tvalid_i),
    .smp_ready_o (s_axis_tready_o),
    .smp_pins_i  (s_axis_tdata_i),
    .evt_valid_o (evt_valid),
    .evt_ready_i (evt_ready),
    .evt_o       (evt)
  );

  // Output register that decouples the scanner from the sink.
  kpe_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .evt_valid_i     (evt_valid),
    .evt_ready_o     (evt_ready),
    .evt_i           (evt),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: tb/keypad_press_event_encoder_tb.sv
// Self-checking testbench for the keypad press event encoder. Holds its own press
// predictor and drives random button samples; depends on kpe_pkg and the RTL top.
module keypad_press_event_encoder_tb;
  import kpe_pkg::*;

  localparam int unsigned NumPins    = 16;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldStart  = 200;
  localparam int unsigned HoldCycles = 300;

  // One button sample waiting to be sent, with its lead-in gap and an optional
  // pause until every predicted event has been seen.
  typedef struct {
    logic [SampleWidth-1:0] sample;
    int unsigned            gap;
    bit                     drain;
  } sample_slot_t;

  // One predicted key event.
  typedef struct {
    logic [KindWidth-1:0] kind;
    logic [CodeWidth-1:0] code;
    logic                 last;
  } key_event_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [SampleWidth-1:0] s_data  = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OutDataW-1:0]    m_data;
  logic                   m_last;

  sample_slot_t           sample_q[$];
  key_event_t             event_q[$];

  // Predictor state.
  logic [SampleWidth-1:0] prev_pins     = '1;
  bit                     first_pending = 1'b1;

  int unsigned n_accepted = 0;
  int unsigned n_events   = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  sample_slot_t head;
  key_event_t   want;

  keypad_press_event_encoder #(
    .NUM_PINS(NumPins)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Event kind that a press of the given pin reports.
  function automatic logic [KindWidth-1:0] press_kind(input int unsigned pin);
    case (pin)
      0:       return KIND_UP;
      1:       return KIND_SELECT;
      2:       return KIND_DOWN;
      8:       return KIND_RIGHT;
      9:       return KIND_LEFT;
      11:      return KIND_BACK;
      14:      return KIND_ANY;
      default: return KIND_MATRIX;
    endcase
  endfunction

  // Key code that a press of the given pin reports: T9 index for matrix pins,
  // a space for the any-key pin, zero for navigation pins.
  function automatic logic [CodeWidth-1:0] press_code(input int unsigned pin);
    case (pin)
      3:       return 8'd8;
      4:       return 8'd4;
      5:       return 8'd1;
      6:       return 8'd3;
      7:       return 8'd7;
      10:      return 8'd6;
      13:      return 8'd2;
      14:      return SPACE_CODE;
      15:      return 8'd5;
      default: return 8'd0;
    endcase
  endfunction

  // Turns an accepted sample into the events it should cause and stores it as
  // the previous sample. The very first sample after reset only gets stored.
  function automatic void record_sample(input logic [SampleWidth-1:0] sample);
    logic [SampleWidth-1:0] newly;
    key_event_t             ev;
    if (first_pending) begin
      first_pending = 1'b0;
      prev_pins     = sample;
      return;
    end
    newly     = prev_pins & ~sample;
    prev_pins = sample;
    for (int unsigned p = 0; p < NumPins; p++) begin
      if (newly[p]) begin
        ev.kind = press_kind(p);
        ev.code = press_code(p);
        // Last event of the sample when no higher scanned pin was pressed.
        ev.last = ((newly >> (p + 1)) & ((1 << NumPins) - 1)) == 0;
        event_q.push_back(ev);
      end
    end
  endfunction

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    n_errors++;
    if (n_errors <= 10) begin
      $display("mismatch on event %0d: %s expected %0d got %0d", n_events, what, exp_v,
               act_v);
    end
  endtask

  // Sender gap before item number idx. Two stretches carry no gaps at all: the
  // first lines up with the long receiver hold so the block backs up.
  function automatic int unsigned pick_gap(input int unsigned idx);
    int unsigned r;
    if ((idx >= 190 && idx < 260) || (idx >= 330 && idx < 370)) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_sample(input logic [SampleWidth-1:0] sample, input bit drain);
    sample_slot_t slot;
    slot.sample = sample;
    slot.gap    = pick_gap(sample_q.size());
    slot.drain  = drain;
    sample_q.push_back(slot);
  endtask

  // Driver: offers queued samples, feeds every accepted one to the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        record_sample(s_data);
        n_accepted <= n_accepted + 1;
      end
      if (!s_valid || s_ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_valid <= 1'b0;
        end else if (sample_q.size() != 0 && !(sample_q[0].drain && event_q.size() != 0)) begin
          head = sample_q.pop_front();
          s_data  <= head.sample;
          s_valid <= 1'b1;
          gap_left = (sample_q.size() != 0) ? sample_q[0].gap : 0;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering samples.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_accepted >= HoldStart) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Monitor: random stalls on the master side, field by field event check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (event_q.size() == 0) begin
          note_mismatch("unexpected event, kind", 0, m_data[2:0]);
        end else begin
          want = event_q.pop_front();
          if (m_data[2:0] !== want.kind) note_mismatch("event_kind", want.kind, m_data[2:0]);
          if (m_data[10:3] !== want.code) note_mismatch("key_code", want.code, m_data[10:3]);
          if (m_last !== want.last) note_mismatch("last_event", want.last, m_last);
          if (m_data[15:11] !== '0) note_mismatch("padding", 0, m_data[15:11]);
        end
        n_events <= n_events + 1;
      end
      if (hold_left != 0) begin
        m_ready <= 1'b0;
      end else if (n_accepted >= 330 && n_accepted < 370) begin
        m_ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        m_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(8, 30);
        m_ready <= 1'b0;
      end
    end
  end

  // Cycle limit; a run that hangs ends here.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [SampleWidth-1:0] next;
    logic [SampleWidth-1:0] gen_prev;
    int unsigned            r;

    // Directed part. The first sample is only stored; the second is held keys;
    // then a full release, all sixteen pressed at once, and a walking zero that
    // presses every pin on its own while releasing the one before.
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'hFFFF, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'hFFFF, 1'b0);
    for (int unsigned p = 0; p < NumPins; p++) begin
      add_sample(~(16'h0001 << p), 1'b0);
    end
    add_sample(16'h5555, 1'b0);
    add_sample(16'hAAAA, 1'b0);
    // Sender waits here until every event so far has come out.
    add_sample(16'hFFFF, 1'b1);
    gen_prev = 16'hFFFF;

    // Random part: release-then-press sequences on top of the previous sample,
    // plus full random samples, bursts, holds and single toggles.
    for (int unsigned i = 0; i < 396; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        next = (gen_prev | 16'($urandom)) & ~(16'h0001 << $urandom_range(0, 15));
      end else if (r < 50) begin
        next = ~(16'($urandom) & 16'($urandom));
      end else if (r < 65) begin
        next = 16'($urandom_range(0, 65535));
      end else if (r < 75) begin
        next = 16'hFFFF;
      end else if (r < 85) begin
        next = 16'h0000;
      end else if (r < 95) begin
        next = gen_prev;
      end else begin
        next = gen_prev ^ (16'h0001 << $urandom_range(0, 15));
      end
      add_sample(next, (i == 280) || ($urandom_range(0, 99) < 2));
      gen_prev = next;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sample_q.size() != 0 || s_valid) @(posedge clk_i);
    while (event_q.size() != 0) @(posedge clk_i);
    // Keep running so that a stray extra event would still be caught.
    repeat (40) @(posedge clk_i);
    if (n_errors == 0 && event_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
